### rtl/core/slcd_pkg.sv
// shared types and constant for the sync/length/checksum deframer
`timescale 1ns / 1ps

package slcd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CHK  = 3'd4
  } slcd_phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_FRAME_END = 2'd2
  } slcd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_buffer;
  } slcd_item_t;

  typedef struct packed {
    slcd_kind_t kind;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       checksum_ok;
  } slcd_result_t;

endpackage

### rtl/core/slcd_in_stage.sv
// input register stage holding one received byte
`timescale 1ns / 1ps

module slcd_in_stage
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  slcd_item_t in_item,
  output logic       item_valid,
  input  logic       item_ready,
  output slcd_item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  slcd_item_t item_r;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/core/slcd_parse_stage.sv
// frame parser state and result register
`timescale 1ns / 1ps

module slcd_parse_stage
  import slcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  output logic         item_ready,
  input  slcd_item_t   item,
  output logic         res_valid,
  input  logic         res_ready,
  output slcd_result_t res
);

  slcd_phase_t  phase_r, phase_nxt, phase_cur;
  logic [7:0]   count_r, count_nxt, count_inc;
  logic [7:0]   sum_r, sum_nxt, sum_add;
  logic [7:0]   type_r, type_nxt;
  logic [7:0]   length_r, length_nxt;
  logic         emit;
  slcd_result_t result;
  logic         res_valid_r, res_valid_nxt;
  slcd_result_t res_r;
  logic         take;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;
  assign phase_cur  = item.first_of_buffer ? PH_HUNT : phase_r;
  assign count_inc  = count_r + 8'd1;
  assign sum_add    = sum_r + item.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    emit       = 1'b0;
    result     = '{kind: KIND_HEADER, frame_type: type_r, frame_length: length_r,
                   payload_byte: 8'd0, payload_index: 8'd0, checksum_ok: 1'b0};
    unique case (phase_cur)
      PH_TYPE: begin
        type_nxt  = item.data_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        length_nxt          = item.data_byte;
        sum_nxt             = sum_add;
        count_nxt           = 8'd0;
        phase_nxt           = (item.data_byte == 8'd0) ? PH_CHK : PH_PAY;
        emit                = 1'b1;
        result.frame_length = item.data_byte;
      end
      PH_PAY: begin
        sum_nxt              = sum_add;
        count_nxt            = count_inc;
        phase_nxt            = (count_inc >= length_r) ? PH_CHK : PH_PAY;
        emit                 = 1'b1;
        result.kind          = KIND_PAYLOAD;
        result.payload_byte  = item.data_byte;
        result.payload_index = count_r;
      end
      PH_CHK: begin
        phase_nxt          = PH_HUNT;
        emit               = 1'b1;
        result.kind        = KIND_FRAME_END;
        result.checksum_ok = (sum_r == item.data_byte);
      end
      default: begin
        // hunt for sync
        phase_nxt = PH_HUNT;
        if (item.data_byte == SYNC_BYTE) begin
          phase_nxt = PH_TYPE;
          sum_nxt   = 8'd0;
        end
      end
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (item_ready) begin
      res_valid_nxt = take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      count_r     <= 8'd0;
      sum_r       <= 8'd0;
      type_r      <= 8'd0;
      length_r    <= 8'd0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (take) begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        sum_r    <= sum_nxt;
        type_r   <= type_nxt;
        length_r <= length_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= result;
    end
  end

endmodule

### rtl/core/sync_length_checksum_deframer_core.sv
// top level of the sync/length/checksum deframer
//
// input channel: one received byte per transfer on in_data_byte, with
// in_first_of_buffer set on the first byte of a new buffer; that byte puts
// the parser back into sync hunt before it is parsed.
// frames: sync 0xAA, type, length, length payload bytes, 8-bit sum checksum
// over type, length and payload.
// result channel: header after the length byte, one result per payload byte
// with its index, and a frame-end result with checksum_ok at the checksum.
// path: a taken byte is held in the input register, then parsed into the
// result register, from which its result is offered; a stalled result
// channel can keep the byte waiting in the input register in between.
// throughput: one byte per cycle while the result channel is not stalled,
// set by the combinational parser update between the two registers.
// a stalled receiver holds the result and stops the parser; the input
// register takes at most one more byte, then in_ready drops.
// reset: parser returns to sync hunt, sums and counts clear, no result valid.
`timescale 1ns / 1ps

module sync_length_checksum_deframer_core
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_frame_type,
  output logic [7:0] out_frame_length,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic       out_checksum_ok
);

  slcd_item_t   in_item;
  slcd_item_t   item;
  logic         item_valid;
  logic         item_ready;
  slcd_result_t res;

  assign in_item = '{data_byte: in_data_byte, first_of_buffer: in_first_of_buffer};

  slcd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  slcd_parse_stage u_parse_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_kind          = res.kind;
  assign out_frame_type    = res.frame_type;
  assign out_frame_length  = res.frame_length;
  assign out_payload_byte  = res.payload_byte;
  assign out_payload_index = res.payload_index;
  assign out_checksum_ok   = res.checksum_ok;

endmodule

### rtl/core/slcd_checker.sv
// port-level checks for the deframer, bound to the top level
`timescale 1ns / 1ps

module slcd_checker
  import slcd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index,
  input logic       out_checksum_ok
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_payload_byte) && $stable(out_payload_index))
    else $error("stalled result changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == KIND_HEADER || out_kind == KIND_PAYLOAD
      || out_kind == KIND_FRAME_END)
    else $error("illegal result kind");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_payload_byte == 8'd0
      && out_payload_index == 8'd0)
    else $error("payload fields set outside a payload result");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_FRAME_END |-> !out_checksum_ok)
    else $error("checksum flag set outside frame end");

endmodule

bind sync_length_checksum_deframer_core slcd_checker u_slcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_checksum_ok   (out_checksum_ok)
);
